>>> sv/mrw_pkg.sv
// Shared types and constants for the Miller-Rabin witness test block.
// No dependencies; imported by mrw_mulmod and miller_rabin_witness_test_top.
`default_nettype none

package mrw_pkg;

  // Working width of candidate and witness (8 to 32).
  localparam int NUM_WIDTH = 32;
  localparam int CNT_W     = $clog2(NUM_WIDTH + 1);  // bit counter of the multiplier
  localparam int RCNT_W    = $clog2(NUM_WIDTH);      // count of factors of two in n-1

  typedef logic [NUM_WIDTH-1:0] num_t;

  // Status of the modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_AZERO,
    S_FACTOR,
    S_POW,
    S_POW_ACC,
    S_POW_SQ,
    S_TEST,
    S_SQ_LOOP,
    S_SQ_CHK,
    S_MUL_GO,
    S_MUL_WAIT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> sv/miller_rabin_witness_test_top.sv
// Top level of the Miller-Rabin witness test: sequencer around one shared
// modular multiplier. Depends on mrw_pkg and mrw_mulmod.
`default_nettype none

// One Miller-Rabin round per item: candidate n and witness a go in, one
// probable_prime flag comes out (1 = passes for this base, 0 = composite).
// Only the low NUM_WIDTH bits of each input field are used. Candidates 0
// and 1 and even candidates above 2 are composite; 2 always passes; a
// witness that reduces to zero modulo n passes. AND the flags of several
// witnesses for a stronger test. The block takes one item at a time and
// drops in_ready while it works. Every modular product goes through one
// bit-serial multiplier: the sequencer starts it in S_MUL_GO, waits in
// S_MUL_WAIT for done and then takes the result in the return state. An
// item takes 1 + P + Q products, where P (up to 2 * NUM_WIDTH - 2)
// is the number of products of the square-and-multiply pass and Q (up to
// NUM_WIDTH - 2) the further squarings; P + Q never exceeds
// 2 * NUM_WIDTH - 2. Candidates below 3 and even candidates finish with
// no product at all. A finished result waits in the output register while
// the next item is accepted.
module miller_rabin_witness_test_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] candidate,
  input  logic [31:0] witness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        probable_prime
);
  import mrw_pkg::*;

  state_t            state;
  state_t            state_next;
  state_t            ret;           // where a product returns to
  num_t              n;
  num_t              nm1;           // n - 1
  num_t              wit;           // raw witness
  num_t              s;             // odd part of n-1, then remaining exponent
  num_t              acc;           // running power, then the squared value x
  num_t              sq;            // running square of the reduced witness
  num_t              op_x;
  num_t              op_y;
  logic [RCNT_W-1:0] r;
  logic [RCNT_W-1:0] j;
  logic              res_bit;
  logic              mm_start;
  num_t              mm_res;
  mm_stat_t          mm_stat;
  logic              out_free;

  mrw_mulmod u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .x     (op_x),
    .y     (op_y),
    .n     (n),
    .res   (mm_res),
    .stat  (mm_stat)
  );

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (n < num_t'(3) || !n[0]) state_next = S_FINISH;
        else                        state_next = S_MUL_GO;
      end
      S_AZERO: begin
        if (mm_res == '0) state_next = S_FINISH;
        else              state_next = S_FACTOR;
      end
      S_FACTOR: begin
        if (s[0]) state_next = S_POW;
      end
      S_POW: begin
        if (s == '0) state_next = S_TEST;
        else         state_next = S_MUL_GO;
      end
      S_POW_ACC: state_next = S_MUL_GO;
      S_POW_SQ:  state_next = S_POW;
      S_TEST: begin
        if (acc == num_t'(1) || acc == nm1) state_next = S_FINISH;
        else                                state_next = S_SQ_LOOP;
      end
      S_SQ_LOOP: begin
        if (j >= r) state_next = S_FINISH;
        else        state_next = S_MUL_GO;
      end
      S_SQ_CHK: begin
        if (mm_res == nm1 || mm_res == num_t'(1)) state_next = S_FINISH;
        else                                      state_next = S_SQ_LOOP;
      end
      S_MUL_GO: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mm_stat.done) state_next = ret;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    mm_start = 1'b0;
    case (state)
      S_IDLE:   in_ready = 1'b1;
      S_MUL_GO: mm_start = 1'b1;
      default: begin
        in_ready = 1'b0;
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          n   <= candidate[NUM_WIDTH-1:0];
          wit <= witness[NUM_WIDTH-1:0];
        end
      end
      S_CHECK: begin
        nm1     <= n - 1'b1;
        // 2 passes; 0, 1 and other even numbers fail
        res_bit <= (n == num_t'(2));
        // reduce the witness: 1 * a mod n
        op_x    <= num_t'(1);
        op_y    <= wit;
        ret     <= S_AZERO;
      end
      S_AZERO: begin
        res_bit <= 1'b1;      // zero witness gives no evidence
        sq      <= mm_res;
        s       <= nm1;
        r       <= '0;
      end
      S_FACTOR: begin
        if (!s[0]) begin
          s <= {1'b0, s[NUM_WIDTH-1:1]};
          r <= r + 1'b1;
        end else begin
          acc <= num_t'(1);
        end
      end
      S_POW: begin
        if (s[0]) begin
          op_x <= acc;
          op_y <= sq;
          ret  <= S_POW_ACC;
        end else begin
          op_x <= sq;
          op_y <= sq;
          ret  <= S_POW_SQ;
        end
      end
      S_POW_ACC: begin
        acc  <= mm_res;
        op_x <= sq;
        op_y <= sq;
        ret  <= S_POW_SQ;
      end
      S_POW_SQ: begin
        sq <= mm_res;
        s  <= {1'b0, s[NUM_WIDTH-1:1]};
      end
      S_TEST: begin
        res_bit <= (acc == num_t'(1)) || (acc == nm1);
        j       <= RCNT_W'(1);
      end
      S_SQ_LOOP: begin
        res_bit <= 1'b0;
        op_x    <= acc;
        op_y    <= acc;
        ret     <= S_SQ_CHK;
      end
      S_SQ_CHK: begin
        acc     <= mm_res;
        j       <= j + 1'b1;
        res_bit <= (mm_res == nm1);
      end
      S_FINISH: begin
        if (out_free) probable_prime <= res_bit;
      end
      default: begin
      end
    endcase
  end

  // The multiplier only reports done while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mm_stat.done |-> state == S_MUL_WAIT)
    else $error("multiplier done outside wait state");

  // No new item while the multiplier still works.
  a_ready_idle_unit: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mm_stat.busy)
    else $error("ready while multiplier busy");

  // An accepted item blocks the input on the next cycle.
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // Operands of the power loop stay reduced modulo n.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_POW) |-> (acc < n && sq < n))
    else $error("power loop operand not reduced");

endmodule

`default_nettype wire

>>> sv/mrw_mulmod.sv
// Bit-serial modular multiplier: res = (x * y) mod n, one bit of y per cycle.
// Requires x < n. Depends on mrw_pkg.
`default_nettype none

module mrw_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mrw_pkg::num_t     x,
  input  mrw_pkg::num_t     y,
  input  mrw_pkg::num_t     n,
  output mrw_pkg::num_t     res,
  output mrw_pkg::mm_stat_t stat
);
  import mrw_pkg::*;

  logic [CNT_W-1:0]     cnt;
  logic                 done;
  num_t                 acc;
  num_t                 xr;
  num_t                 yr;
  num_t                 nr;
  logic [NUM_WIDTH+1:0] t;
  logic [NUM_WIDTH+1:0] n1;
  logic [NUM_WIDTH+1:0] n2;
  logic [NUM_WIDTH+1:0] step;

  // acc < n, so 2*acc + x < 3n: at most one of n or 2n comes off.
  always_comb begin
    t  = {1'b0, acc, 1'b0} + (yr[NUM_WIDTH-1] ? {2'b00, xr} : '0);
    n1 = {2'b00, nr};
    n2 = {1'b0, nr, 1'b0};
    if (t >= n2) begin
      step = t - n2;
    end else if (t >= n1) begin
      step = t - n1;
    end else begin
      step = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(NUM_WIDTH);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      nr  <= n;
    end else if (cnt != '0) begin
      acc <= step[NUM_WIDTH-1:0];
      yr  <= {yr[NUM_WIDTH-2:0], 1'b0};
    end
  end

  assign res       = acc;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

`default_nettype wire
